FILE: design/srt_pkg.sv
package srt_pkg;

   // configuration register indexes
   localparam logic CSR_GEOMETRY_MODE = 1'b0;
   localparam logic CSR_SIDE_SELECT   = 1'b1;

   // pi/2 scaled to Q30
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // Taylor series divisors (2k-1)*2k, k = 1..12
   function automatic logic [9:0] taylor_div(input logic [3:0] k);
      logic [9:0] r;
      begin
         case (k)
            4'd1:    r = 10'd2;
            4'd2:    r = 10'd12;
            4'd3:    r = 10'd30;
            4'd4:    r = 10'd56;
            4'd5:    r = 10'd90;
            4'd6:    r = 10'd132;
            4'd7:    r = 10'd182;
            4'd8:    r = 10'd240;
            4'd9:    r = 10'd306;
            4'd10:   r = 10'd380;
            4'd11:   r = 10'd462;
            default: r = 10'd552;
         endcase
         return r;
      end
   endfunction

   // side information carried through the pipeline
   typedef struct packed {
      logic trans;
      logic side;
   } mode_type;

endpackage

FILE: design/stokes_rotation_terms_top.sv
// Stokes rotation terms: cos(2i) and sin(2i) of the polarization rotation angle
// for one scattering geometry.
// Input channel req_: one geometry per transfer (two direction cosines, two
// azimuths). Result channel rsp_: cos_double, sin_double and the degenerate
// flag for that geometry, in input order, one result per input.
// Configuration port csr_: geometry_mode (index 0) and side_select (index 1); the
// user must see they are written only while no item is in flight (not enforced).
// Throughput: one item per cycle while the receiver is not stalling. The
// pipeline is a chain of square roots, multiplies and one divide; each square
// root and the divide run one result bit per stage, and the cosine series takes
// two stages per term.
// Every stage has a valid bit; the whole pipeline advances when the output
// register is empty or being taken, so a stalled receiver freezes all stages
// and nothing is lost or repeated.
// Reset clears all valid bits and loads geometry_mode=1 and side_select=0.
module stokes_rotation_terms_top #(
   parameter int FRAC_BITS  = 15,
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mu_out[15:0], mu_in[31:16], azimuth_out[47:32], azimuth_in[63:48]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cos_double[15:0], sin_double[31:16], degenerate[32], zero fill
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import srt_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int W   = 2*F + 4;          // wide signed Q2F workspace
   localparam int RB  = F + 2;            // root result bits
   localparam int A   = ANGLE_BITS;
   // stage counts
   localparam int NS1 = 25;               // cosine series: x2, 12 terms of two stages
   localparam int NQ  = RB;               // isqrt steps

   logic trans_ff, side_ff;
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff <= 1'b1;
         side_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GEOMETRY_MODE: trans_ff <= csr_wdata;
            CSR_SIDE_SELECT:   side_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input conversion to QF (floor)
   function automatic logic signed [F+1:0] to_qf(input logic [15:0] raw);
      logic [16+F:0] off;
      begin
         off = {{F{1'b0}}, raw ^ 16'h8000, 1'b0} >> 1;
         off = (off << F) >> 15;
         return $signed(off[F+1:0]) - $signed({2'b01, {F{1'b0}}});
      end
   endfunction

   // one step of a bit-serial square root (two radicand bits per step)
   typedef struct packed {
      logic [2*RB-1:0] rem;
      logic [RB-1:0]   root;
      logic [2*RB-1:0] rad;
   } sq_type;

   function automatic sq_type sq_step(input sq_type s);
      sq_type o;
      logic [2*RB+1:0] t;
      logic [2*RB+1:0] trial;
      begin
         t     = {s.rem, s.rad[2*RB-1 -: 2]};
         trial = {{RB{1'b0}}, s.root, 2'b01};
         o.rad = s.rad << 2;
         if (t >= trial) begin
            o.rem  = (2*RB)'(t - trial);
            o.root = {s.root[RB-2:0], 1'b1};
         end else begin
            o.rem  = (2*RB)'(t);
            o.root = {s.root[RB-2:0], 1'b0};
         end
         return o;
      end
   endfunction

   // -------------------------------------------------------------------
   // stage group 1: convert, azimuth fold and x, series terms, sines
   // -------------------------------------------------------------------
   typedef struct packed {
      mode_type                mode;
      logic signed [F+1:0]     mo;
      logic signed [F+1:0]     mi;
      logic                    neg;
      logic [31:0]             x2;
      logic [31:0]             term;
      logic signed [32:0]      sum;
      sq_type                  so;
      sq_type                  si;
   } s1_type;

   localparam int N1 = NS1;
   logic   [N1-1:0] v1_ff;
   s1_type          p1_ff [N1];

   s1_type  e0;
   logic [15:0]     dd;
   logic [A+16:0]   pp;
   logic [A:0]      pf;
   logic [A+31:0]   xw;
   always_comb begin
      e0       = '0;
      e0.mode  = '{trans: trans_ff, side: side_ff};
      e0.mo    = to_qf(req_tdata[15:0]);
      e0.mi    = to_qf(req_tdata[31:16]);
      dd       = req_tdata[47:32] - req_tdata[63:48];
      if (A >= 16) pp = (A+17)'(dd) << (A-16);
      else         pp = (A+17)'(dd) >> (16-A);
      pf = pp[A:0];
      if (pf > (A+1)'(1) << (A-1)) pf = ((A+1)'(1) << A) - pf;
      if (pf > (A+1)'(1) << (A-2)) begin
         pf     = ((A+1)'(1) << (A-1)) - pf;
         e0.neg = 1'b1;
      end
      xw      = ((A+32)'(pf) * (A+32)'(HALF_PI_Q30)) >> (A-2);
      // x <= pi/2 in Q30 fits 31 bits; x2 computed in the next stage
      e0.x2   = xw[31:0];
      e0.term = 32'h4000_0000;
      e0.sum  = 33'sh0_4000_0000;
      e0.so.rad = (2*RB)'((64'd1 << (2*F)) - 64'(e0.mo * e0.mo));
      e0.si.rad = (2*RB)'((64'd1 << (2*F)) - 64'(e0.mi * e0.mi));
   end

   // series/sine steps: stage 0 squares x; each term takes a product stage
   // and then a divide stage by reciprocal multiplication
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= '0;
      else if (adv) v1_ff <= {v1_ff[N1-2:0], req_tvalid};
   end

   genvar g;
   generate
      for (g = 0; g < N1; g++) begin : g_s1
         // exact floor division of a 32-bit value by the term divisor
         localparam int unsigned DV = taylor_div(4'((g + 1) / 2));
         localparam int LS = $clog2(DV);
         localparam logic [32:0] RM = 33'((64'd1 << (32 + LS)) / 64'(DV) + 64'd1);
         s1_type cur, nxt;
         logic [63:0] m;
         logic [64:0] q;
         if (g == 0) begin : g_a
            assign cur = e0;
         end else begin : g_b
            assign cur = p1_ff[g-1];
         end
         always_comb begin
            nxt = cur;
            m   = '0;
            q   = '0;
            if (g == 0) begin
               m = 64'(cur.x2) * 64'(cur.x2);
               nxt.x2 = 32'(m >> 30);
            end else if (g % 2 == 1) begin
               m = 64'(cur.term) * 64'(cur.x2);
               nxt.term = 32'(m >> 30);
            end else begin
               q = 65'(cur.term) * 65'(RM);
               nxt.term = 32'(q >> (32 + LS));
               if ((g / 2) % 2 == 1) nxt.sum = cur.sum - $signed({1'b0, nxt.term});
               else                  nxt.sum = cur.sum + $signed({1'b0, nxt.term});
            end
            if (g < NQ) begin
               nxt.so = sq_step(cur.so);
               nxt.si = sq_step(cur.si);
            end
         end
         always_ff @(posedge clock) if (adv) p1_ff[g] <= nxt;
      end
   endgenerate

   // remaining sine steps if RB exceeds the series depth
   localparam int NR = (NQ > N1) ? NQ - N1 : 0;
   localparam int N2 = NR + 2;
   typedef struct packed {
      mode_type            mode;
      logic signed [F+1:0] mo;
      logic signed [F+1:0] mi;
      logic signed [F+1:0] cd;
      sq_type              so;
      sq_type              si;
   } s2_type;
   logic   [N2-1:0] v2_ff;
   s2_type          p2_ff [N2];

   s2_type e2;
   logic signed [32:0] sm;
   logic [30:0]        su;
   always_comb begin
      e2.mode = p1_ff[N1-1].mode;
      e2.mo   = p1_ff[N1-1].mo;
      e2.mi   = p1_ff[N1-1].mi;
      e2.so   = p1_ff[N1-1].so;
      e2.si   = p1_ff[N1-1].si;
      sm = p1_ff[N1-1].sum;
      if (sm < 0) sm = '0;
      if (sm > 33'sh0_4000_0000) sm = 33'sh0_4000_0000;
      su = 31'(sm);
      if (F < 30) su = 31'((32'(su) + (32'd1 << (29-F))) >> (30-F));
      e2.cd = p1_ff[N1-1].neg ? -$signed((F+2)'(su)) : $signed((F+2)'(su));
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= '0;
      else if (adv) v2_ff <= {v2_ff[N2-2:0], v1_ff[N1-1]};
   end

   generate
      for (g = 0; g < N2; g++) begin : g_s2
         s2_type cur, nxt;
         if (g == 0) begin : g_a
            assign cur = e2;
         end else begin : g_b
            assign cur = p2_ff[g-1];
         end
         always_comb begin
            nxt = cur;
            if (g + N1 < NQ) begin
               nxt.so = sq_step(cur.so);
               nxt.si = sq_step(cur.si);
            end
         end
         always_ff @(posedge clock) if (adv) p2_ff[g] <= nxt;
      end
   endgenerate

   // -------------------------------------------------------------------
   // products: so*si, mo*mi, mi*so, mo*si, mi*cd; then ca and numerator terms
   // -------------------------------------------------------------------
   typedef struct packed {
      mode_type            mode;
      logic signed [F+1:0] cd;
      logic signed [W-1:0] sosi;
      logic signed [W-1:0] momi;
      logic signed [W-1:0] miso;
      logic signed [W-1:0] mosi;
      logic signed [W-1:0] micd;
      logic signed [F+1:0] so;
   } s3_type;
   logic   v3_ff;
   s3_type p3_ff;
   s3_type e3;
   logic signed [F+1:0] so3, si3;
   always_comb begin
      so3     = $signed({1'b0, p2_ff[N2-1].so.root[F:0]});
      si3     = $signed({1'b0, p2_ff[N2-1].si.root[F:0]});
      e3.mode = p2_ff[N2-1].mode;
      e3.cd   = p2_ff[N2-1].cd;
      e3.so   = so3;
      e3.sosi = W'(so3 * si3);
      e3.momi = W'(p2_ff[N2-1].mo * p2_ff[N2-1].mi);
      e3.miso = W'(p2_ff[N2-1].mi * so3);
      e3.mosi = W'(p2_ff[N2-1].mo * si3);
      e3.micd = W'(p2_ff[N2-1].mi * p2_ff[N2-1].cd);
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff[N2-1];
   end
   always_ff @(posedge clock) if (adv) p3_ff <= e3;

   // second products: floor(x/2^F)*cd or floor(x/2^F)*so
   typedef struct packed {
      mode_type            mode;
      logic signed [W-1:0] ca;
      logic signed [W-1:0] num;
   } s4_type;
   logic   v4_ff;
   s4_type p4_ff;
   s4_type e4;
   logic signed [W-1:0] t1, t2, t3;
   logic signed [W-1:0] cq;
   always_comb begin
      e4.mode = p3_ff.mode;
      t1 = W'((p3_ff.sosi >>> F) * p3_ff.cd);
      cq = p3_ff.mode.trans ? t1 + p3_ff.momi : t1 - p3_ff.momi;
      cq = cq >>> F;
      if (cq > $signed(W'(1) << F))  cq = $signed(W'(1) << F);
      if (cq < -$signed(W'(1) << F)) cq = -$signed(W'(1) << F);
      e4.ca = cq;
      t2 = W'((p3_ff.micd >>> F) * p3_ff.so);
      t3 = W'((p3_ff.mosi >>> F) * p3_ff.cd);
      if (p3_ff.mode.side)
         e4.num = p3_ff.mode.trans ? p3_ff.mosi - t2 : -t2 - p3_ff.mosi;
      else
         e4.num = p3_ff.mode.trans ? p3_ff.miso - t3 : p3_ff.miso + t3;
   end
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) if (adv) p4_ff <= e4;

   // den = isqrt(2^2F - ca^2), one bit per stage
   typedef struct packed {
      logic                sgn;
      logic [W-1:0]        mag;
      sq_type              dq;
   } s5_type;
   logic   [NQ-1:0] v5_ff;
   s5_type          p5_ff [NQ];
   s5_type e5;
   always_comb begin
      e5     = '0;
      e5.sgn = p4_ff.num < 0;
      e5.mag = e5.sgn ? W'(-p4_ff.num) : W'(p4_ff.num);
      e5.dq.rad = (2*RB)'((64'd1 << (2*F)) - 64'(p4_ff.ca * p4_ff.ca));
   end
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= '0;
      else if (adv) v5_ff <= {v5_ff[NQ-2:0], v4_ff};
   end
   generate
      for (g = 0; g < NQ; g++) begin : g_s5
         s5_type cur, nxt;
         if (g == 0) begin : g_a
            assign cur = e5;
         end else begin : g_b
            assign cur = p5_ff[g-1];
         end
         always_comb begin
            nxt    = cur;
            nxt.dq = sq_step(cur.dq);
         end
         always_ff @(posedge clock) if (adv) p5_ff[g] <= nxt;
      end
   endgenerate

   // restoring divide mag / den, F+1 quotient bits, one per stage
   localparam int ND = F + 1;
   typedef struct packed {
      logic           sgn;
      logic           deg;
      logic           sat;
      logic [F:0]     den;
      logic [W-1:0]   rem;
      logic [F:0]     quo;
   } s6_type;
   logic   [ND-1:0] v6_ff;
   s6_type          p6_ff [ND];
   s6_type e6;
   always_comb begin
      e6     = '0;
      e6.sgn = p5_ff[NQ-1].sgn;
      e6.den = p5_ff[NQ-1].dq.root[F:0];
      e6.deg = (e6.den == '0);
      e6.sat = (2*W)'(p5_ff[NQ-1].mag) >= ((2*W)'(e6.den) << F);
      e6.rem = p5_ff[NQ-1].mag;
   end
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= '0;
      else if (adv) v6_ff <= {v6_ff[ND-2:0], v5_ff[NQ-1]};
   end
   generate
      for (g = 0; g < ND; g++) begin : g_s6
         s6_type cur, nxt;
         logic [2*W-1:0] sh;
         if (g == 0) begin : g_a
            assign cur = e6;
         end else begin : g_b
            assign cur = p6_ff[g-1];
         end
         always_comb begin
            nxt = cur;
            sh  = (2*W)'(cur.den) << (F - g);
            if ((2*W)'(cur.rem) >= sh) begin
               nxt.rem = W'((2*W)'(cur.rem) - sh);
               nxt.quo = cur.quo | ((F+1)'(1) << (F - g));
            end
         end
         always_ff @(posedge clock) if (adv) p6_ff[g] <= nxt;
      end
   endgenerate

   // c and the final sine sqrt(1-c^2)
   typedef struct packed {
      logic                deg;
      logic signed [F+1:0] c;
      sq_type              sq;
   } s7_type;
   logic   [NQ-1:0] v7_ff;
   s7_type          p7_ff [NQ];
   s7_type e7;
   logic [F:0] cm;
   always_comb begin
      e7     = '0;
      e7.deg = p6_ff[ND-1].deg;
      cm     = p6_ff[ND-1].sat ? (F+1)'(1) << F : p6_ff[ND-1].quo;
      e7.c   = p6_ff[ND-1].sgn ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
      e7.sq.rad = (2*RB)'((64'd1 << (2*F)) - 64'(e7.c * e7.c));
   end
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= '0;
      else if (adv) v7_ff <= {v7_ff[NQ-2:0], v6_ff[ND-1]};
   end
   generate
      for (g = 0; g < NQ; g++) begin : g_s7
         s7_type cur, nxt;
         if (g == 0) begin : g_a
            assign cur = e7;
         end else begin : g_b
            assign cur = p7_ff[g-1];
         end
         always_comb begin
            nxt    = cur;
            nxt.sq = sq_step(cur.sq);
         end
         always_ff @(posedge clock) if (adv) p7_ff[g] <= nxt;
      end
   endgenerate

   // output rounding and saturation
   function automatic logic [15:0] to_out(input logic signed [W:0] v);
      logic signed [W:0] r;
      begin
         r = (v + $signed((W+1)'(1) << (2*F-16))) >>> (2*F-15);
         if (r > 32767)  r = 32767;
         if (r < -32768) r = -32768;
         return r[15:0];
      end
   endfunction

   logic               out_v_ff;
   logic [39:0]        out_d_ff;
   logic signed [W:0]  cc, ss;
   s7_type             fin;
   always_comb begin
      fin = p7_ff[NQ-1];
      cc  = (W+1)'(2 * fin.c * fin.c) - ((W+1)'(1) << (2*F));
      ss  = (W+1)'(2 * fin.c * $signed({1'b0, fin.sq.root[F:0]}));
   end
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= v7_ff[NQ-1];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         if (fin.deg) out_d_ff <= {7'd0, 1'b1, 16'd0, 16'h7fff};
         else         out_d_ff <= {7'd0, 1'b0, to_out(ss), to_out(cc)};
      end
   end
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

endmodule
